// ----- rtl/core/bba_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and interface structs of the bitmap block allocator.
// No dependencies; imported by every module of the block.
package bba_pkg;

	localparam int MAX_BLOCKS  = 4096;
	localparam int WORD_BITS   = 32;
	localparam int NUM_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WADDR_W     = $clog2(NUM_WORDS);
	localparam int NW_W        = WADDR_W + 1;
	localparam int CNT_W       = 13;
	localparam int BLK_W       = 12;
	localparam int CMD_W       = 2;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_MARK  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// bitmap memory access, one read and one write per cycle
	typedef struct packed {
		logic                 rd_en;
		logic [WADDR_W-1:0]   rd_addr;
		logic                 wr_en;
		logic [WADDR_W-1:0]   wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} mem_req_t;

	// per-word job for the shared word unit
	typedef struct packed {
		logic [WADDR_W-1:0] word_idx;
		logic [CNT_W-1:0]   lo;
		logic [CNT_W-1:0]   hi;
		logic [CNT_W-1:0]   lim;
		logic [CNT_W-1:0]   count;
		logic [CNT_W-1:0]   carry;
		logic               clear_mode;
	} wu_ctrl_t;

	typedef struct packed {
		logic                 found;
		logic [BIT_W-1:0]     hit_pos;
		logic [CNT_W-1:0]     carry_out;
		logic [WORD_BITS-1:0] new_word;
		logic [BIT_W:0]       free_bits;
	} wu_res_t;

endpackage

// ----- rtl/core/bba_bitmap_mem.sv -----
`timescale 1ns / 1ps
// Usage bitmap storage: one word per row, registered read, per-row valid bits.
// Depends on bba_pkg. A row never written reads as all ones (all used).
module bba_bitmap_mem import bba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             req,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0] raw_q;
	logic                 row_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_q     <= mem_q[req.rd_addr];
			row_vld_q <= vld_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	assign rd_data = row_vld_q ? raw_q : '1;

endmodule

// ----- rtl/core/bba_word_unit.sv -----
`timescale 1ns / 1ps
// Shared per-word datapath: first-fit run search with carried run length,
// range set/clear and free-bit count of one bitmap word. Depends on bba_pkg.
module bba_word_unit import bba_pkg::*; (
	input  wu_ctrl_t             ctrl,
	input  logic [WORD_BITS-1:0] old_word,
	output wu_res_t              res
);

	// bits of word w whose block index is below n
	function automatic logic [WORD_BITS-1:0] below_mask(logic [WADDR_W-1:0] w,
			logic [CNT_W-1:0] n);
		logic [CNT_W-1:0]     nw;
		logic [CNT_W-1:0]     wz;
		logic [WORD_BITS-1:0] ones;
		nw   = n >> BIT_W;
		wz   = CNT_W'(w);
		ones = '1;
		if (wz < nw) begin
			return ones;
		end else if (wz > nw) begin
			return '0;
		end else begin
			return ~(ones << n[BIT_W-1:0]);
		end
	endfunction

	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] rng_mask;
	logic [WORD_BITS-1:0] new_word;
	logic [BIT_W:0]       lu [BIT_W+1][WORD_BITS];  // last used position + 1, 0 = none
	logic [CNT_W:0]       runlen [WORD_BITS];
	logic [WORD_BITS-1:0] hit;

	assign lim_mask = below_mask(ctrl.word_idx, ctrl.lim);
	assign rng_mask = below_mask(ctrl.word_idx, ctrl.hi) & ~below_mask(ctrl.word_idx, ctrl.lo);

	always_comb begin
		if (ctrl.clear_mode) begin
			new_word = old_word & ~rng_mask;
			if (ctrl.word_idx == '0) begin
				new_word[0] = 1'b1;  // block 0 stays used
			end
		end else begin
			new_word = old_word | rng_mask;
		end
	end

	// prefix scan for the nearest used bit at or below each position
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			lu[0][i] = old_word[i] ? (BIT_W+1)'(i + 1) : '0;
		end
		for (int k = 0; k < BIT_W; k++) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (i >= (1 << k) && lu[k][i] == '0) begin
					lu[k+1][i] = lu[k][i - (1 << k)];
				end else begin
					lu[k+1][i] = lu[k][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lu[BIT_W][i] == '0) begin
				runlen[i] = {1'b0, ctrl.carry} + (CNT_W+1)'(i + 1);
			end else begin
				runlen[i] = (CNT_W+1)'(i + 1) - (CNT_W+1)'(lu[BIT_W][i]);
			end
			hit[i] = ~old_word[i] & lim_mask[i] & (runlen[i] >= {1'b0, ctrl.count});
		end
	end

	always_comb begin
		res.found   = |hit;
		res.hit_pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				res.hit_pos = BIT_W'(i);
			end
		end
		res.carry_out = runlen[WORD_BITS-1][CNT_W-1:0];
		res.new_word  = new_word;
		res.free_bits = (BIT_W+1)'($countones(~new_word & lim_mask));
	end

endmodule

// ----- rtl/core/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
// Bitmap block allocator top level: command sequencer, config and output register.
// Depends on bba_pkg, bba_bitmap_mem and bba_word_unit.
//
// Usage:
//   s_* channel takes one command per transfer: s_tuser is the command
//   (allocate, free, mark used), s_tdata carries start block and count.
//   m_* channel returns exactly one result per command: m_tuser is ok,
//   m_tdata carries alloc_start and the free count after the command.
//   cfg_* writes total_blocks; write it only while no command is in flight.
// Passes (W = words covering total_blocks, W = 128 at 4096 blocks):
//   free / mark used / unknown: one update pass over W words.
//   allocate: search pass over up to W words (stops at the first fit), then
//   the update pass over W words.
//   The bitmap memory port reads one word and writes one per cycle;
//   s_tready is high only between commands.
// Reset: every block reads as used (per-row valid bits), total_blocks = 4096.
// Stall: a finished result waits in the output register; the next command
//   is accepted and processed meanwhile, and its result holds off only until
//   the register is free.
module bitmap_block_allocator import bba_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] start_block, [24:12] block_count
	input  logic [CMD_W-1:0]       s_tuser,   // [1:0] cmd
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] alloc_start, [24:12] free_count
	output logic                   m_tuser,   // [0] ok
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CNT_W-1:0]       cfg_data   // total_blocks
);

	// end of a range, clipped at the managed block count
	function automatic logic [CNT_W-1:0] clip_end(logic [CNT_W:0] e, logic [CNT_W-1:0] lim);
		return (e > {1'b0, lim}) ? lim : e[CNT_W-1:0];
	endfunction

	// control registers
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   total_q;
	logic               m_tvalid_q, m_tvalid_d;
	logic               rd_vld_s1;
	// command context
	cmd_t               cmd_q, cmd_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   lo_q, lo_d;
	logic [CNT_W-1:0]   hi_q, hi_d;
	logic [CNT_W-1:0]   carry_q, carry_d;
	logic               ok_q, ok_d;
	logic [BLK_W-1:0]   astart_q, astart_d;
	logic [CNT_W-1:0]   acc_q, acc_d;
	logic [NW_W-1:0]    rd_ptr_q, rd_ptr_d;
	logic               rd_scan_s1;
	logic [WADDR_W-1:0] rd_idx_s1;
	// output register payload
	logic               out_ok_q;
	logic [BLK_W-1:0]   out_start_q;
	logic [CNT_W-1:0]   out_free_q;
	logic               load_out;

	logic [CNT_W-1:0]     lim;
	logic [CNT_W:0]       span;
	logic [NW_W-1:0]      nwords;
	logic [NW_W-1:0]      npass;
	mem_req_t             mem_req;
	logic [WORD_BITS-1:0] rd_data;
	wu_ctrl_t             wu_ctrl;
	wu_res_t              wu_res;

	bba_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	bba_word_unit u_word (
		.ctrl     (wu_ctrl),
		.old_word (rd_data),
		.res      (wu_res)
	);

	assign lim    = (total_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_q;
	assign span   = {1'b0, lim} + (CNT_W+1)'(WORD_BITS - 1);
	assign nwords = NW_W'(span >> BIT_W);
	// the update pass always touches word 0 so a free can pin block 0
	assign npass  = (nwords == '0) ? NW_W'(1) : nwords;

	always_comb begin
		wu_ctrl.word_idx   = rd_idx_s1;
		wu_ctrl.lo         = lo_q;
		wu_ctrl.hi         = hi_q;
		wu_ctrl.lim        = lim;
		wu_ctrl.count      = count_q;
		wu_ctrl.carry      = carry_q;
		wu_ctrl.clear_mode = (cmd_q == CMD_FREE);
	end

	// sequencer: next state and datapath
	always_comb begin
		logic [CNT_W:0] run_end;
		logic [CNT_W:0] first;
		state_d    = state_q;
		cmd_d      = cmd_q;
		count_d    = count_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		carry_d    = carry_q;
		ok_d       = ok_q;
		astart_d   = astart_q;
		acc_d      = acc_q;
		rd_ptr_d   = rd_ptr_q;
		s_tready   = 1'b0;
		load_out   = 1'b0;
		m_tvalid_d = m_tvalid_q & ~m_tready;
		run_end    = (CNT_W+1)'({rd_idx_s1, wu_res.hit_pos}) + (CNT_W+1)'(1);
		first      = run_end - {1'b0, count_q};

		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = rd_ptr_q[WADDR_W-1:0];
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = rd_idx_s1;
		mem_req.wr_data = wu_res.new_word;

		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd_d    = cmd_t'(s_tuser);
					count_d  = s_tdata[BLK_W +: CNT_W];
					carry_d  = '0;
					rd_ptr_d = '0;
					acc_d    = '0;
					ok_d     = 1'b0;
					astart_d = '0;
					lo_d     = '0;
					hi_d     = '0;
					state_d  = ST_UPDATE;
					case (cmd_t'(s_tuser))
						CMD_ALLOC: begin
							if (s_tdata[BLK_W +: CNT_W] != '0 && nwords != '0) begin
								state_d = ST_SCAN;
							end
						end
						CMD_FREE, CMD_MARK: begin
							ok_d = 1'b1;
							lo_d = CNT_W'(s_tdata[BLK_W-1:0]);
							hi_d = clip_end((CNT_W+1)'(s_tdata[BLK_W-1:0]) +
								(CNT_W+1)'(s_tdata[BLK_W +: CNT_W]), lim);
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (rd_ptr_q < nwords) begin
					mem_req.rd_en = 1'b1;
					rd_ptr_d      = rd_ptr_q + NW_W'(1);
				end
				if (rd_vld_s1 && rd_scan_s1) begin
					carry_d = wu_res.carry_out;
					if (wu_res.found) begin
						ok_d     = 1'b1;
						astart_d = first[BLK_W-1:0];
						lo_d     = first[CNT_W-1:0];
						hi_d     = clip_end(run_end, lim);
						rd_ptr_d = '0;
						state_d  = ST_UPDATE;
					end else if (NW_W'(rd_idx_s1) == nwords - NW_W'(1)) begin
						rd_ptr_d = '0;
						state_d  = ST_UPDATE;
					end
				end
			end
			ST_UPDATE: begin
				if (rd_ptr_q < npass) begin
					mem_req.rd_en = 1'b1;
					rd_ptr_d      = rd_ptr_q + NW_W'(1);
				end
				// late reads left over from the search pass are dropped
				if (rd_vld_s1 && !rd_scan_s1) begin
					mem_req.wr_en = 1'b1;
					acc_d         = acc_q + CNT_W'(wu_res.free_bits);
					if (NW_W'(rd_idx_s1) == npass - NW_W'(1)) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					load_out   = 1'b1;
					m_tvalid_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= CNT_W'(MAX_BLOCKS);
			m_tvalid_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			m_tvalid_q <= m_tvalid_d;
			rd_vld_s1  <= mem_req.rd_en;
			if (cfg_valid) begin
				total_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		count_q    <= count_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		carry_q    <= carry_d;
		ok_q       <= ok_d;
		astart_q   <= astart_d;
		acc_q      <= acc_d;
		rd_ptr_q   <= rd_ptr_d;
		rd_scan_s1 <= (state_q == ST_SCAN);
		rd_idx_s1  <= mem_req.rd_addr;
		if (load_out) begin
			out_ok_q    <= ok_q;
			out_start_q <= astart_q;
			out_free_q  <= acc_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_ok_q;
	assign m_tdata   = OUT_TDATA_W'({out_free_q, out_start_q});

	// bitmap is only written during the update pass
	a_wr_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> state_q == ST_UPDATE)
		else $error("bitmap write outside update pass");

	// a granted run lies fully inside the managed range
	a_run_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && cmd_q == CMD_ALLOC && ok_q) |->
		((CNT_W+1)'(lo_q) + (CNT_W+1)'(count_q) == (CNT_W+1)'(hi_q)))
		else $error("allocated run clipped");

	a_free_le_lim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> acc_q <= lim)
		else $error("free count exceeds managed blocks");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !(cmd_q == CMD_ALLOC && ok_q)) |-> astart_q == '0)
		else $error("alloc_start set without a granted run");

endmodule
